// ----- hw/rtl/lfu_pkg.sv -----
`timescale 1ns / 1ps

package lfu_pkg;

    localparam int NUM_PAGES       = 8;
    localparam int MAX_FRAMES      = 8;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int PAGE_W          = 4;
    localparam int FRAME_W         = 3;
    localparam int CFG_W           = 4;
    localparam int FRAME_CNT_W     = FRAME_W + 1;
    localparam int PAGE_IDX_W      = $clog2(NUM_PAGES);
    localparam int FRAMES_RESET    = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_BUMP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
        logic bump;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic page_valid;
        logic scan_last;
        logic out_free;
    } t_stat;

endpackage

// ----- hw/rtl/lfu_page_replacement.sv -----
`timescale 1ns / 1ps
// An accepted word is registered, its n active frames scanned one per cycle, the chosen
// frame committed, its counter bumped and the result loaded; then a new word is taken.
// A reserved page (0 or beyond the page range) skips the scan, commit and bump.
// The result register lets the scan finish while the previous word waits downstream.
// Reset is synchronous, active low: frames empty, counters zero, frame count 8.
module lfu_page_replacement
    import lfu_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_W-1:0]   i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [PAGE_W-1:0]  i_page_id,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_was_hit,
    output logic [FRAME_W-1:0] o_frame_index,
    output logic [PAGE_W-1:0]  o_evicted_page
);

    t_cmd  cmd;
    t_stat stat;

    lfu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lfu_dp #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_page_id      (i_page_id),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_was_hit      (o_was_hit),
        .o_frame_index  (o_frame_index),
        .o_evicted_page (o_evicted_page)
    );

endmodule

// ----- hw/rtl/lfu_ctrl.sv -----
`timescale 1ns / 1ps

module lfu_ctrl
    import lfu_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // a reserved page touches nothing
                if (!i_stat.page_valid) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.scan = 1'b1;
                    if (i_stat.scan_last) begin
                        n_state = ST_COMMIT;
                    end
                end
            end
            ST_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = ST_BUMP;
            end
            ST_BUMP: begin
                o_cmd.bump = 1'b1;
                n_state    = ST_DONE;
            end
            ST_DONE: begin
                // hold until the result register is free
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/lfu_dp.sv -----
`timescale 1ns / 1ps

module lfu_dp
    import lfu_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_W-1:0]   i_cfg_wdata,
    input  logic [PAGE_W-1:0]  i_page_id,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_was_hit,
    output logic [FRAME_W-1:0] o_frame_index,
    output logic [PAGE_W-1:0]  o_evicted_page
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [PAGE_W-1:0]      r_frames [MAX_FRAMES];
    logic [COUNT_WIDTH-1:0] r_counts [NUM_PAGES];
    logic [CFG_W-1:0]       r_frames_in_use;

    logic [PAGE_W-1:0]      r_page;
    logic                   r_page_valid;
    logic [FRAME_W-1:0]     r_idx;
    logic                   r_hit;
    logic [FRAME_W-1:0]     r_match_idx;
    logic                   r_empty_found;
    logic [FRAME_W-1:0]     r_empty_idx;
    logic [COUNT_WIDTH-1:0] r_min_cnt;
    logic [FRAME_W-1:0]     r_min_idx;
    logic [PAGE_W-1:0]      r_min_page;
    logic [FRAME_W-1:0]     r_frame;
    logic [PAGE_W-1:0]      r_evict;

    logic [FRAME_CNT_W-1:0] n_act;
    logic [FRAME_W-1:0]     last_idx;
    logic [PAGE_W-1:0]      cur_page;
    logic [PAGE_W-1:0]      cur_page_m1;
    logic [PAGE_W-1:0]      req_page_m1;
    logic [PAGE_W-1:0]      min_page_m1;
    logic [PAGE_IDX_W-1:0]  cnt_addr;
    logic [COUNT_WIDTH-1:0] cnt_rd;
    logic [COUNT_WIDTH-1:0] cur_cnt;
    logic [FRAME_W-1:0]     sel_frame;
    logic                   do_evict;
    logic                   page_ok;

    // frame count 0 acts as 1, anything above the frame store as its depth
    always_comb begin
        if (r_frames_in_use == '0) begin
            n_act = FRAME_CNT_W'(1);
        end else if (r_frames_in_use > CFG_W'(MAX_FRAMES)) begin
            n_act = FRAME_CNT_W'(MAX_FRAMES);
        end else begin
            n_act = FRAME_CNT_W'(r_frames_in_use);
        end
    end

    assign last_idx    = FRAME_W'(n_act - FRAME_CNT_W'(1));
    assign page_ok     = (i_page_id != '0) && (i_page_id <= PAGE_W'(NUM_PAGES));

    assign cur_page    = r_frames[r_idx];
    assign cur_page_m1 = cur_page - PAGE_W'(1);
    assign req_page_m1 = r_page - PAGE_W'(1);
    assign min_page_m1 = r_min_page - PAGE_W'(1);

    // one read port on the counters: scanned frame's page, or the request
    assign cnt_addr = i_cmd.bump ? req_page_m1[PAGE_IDX_W-1:0]
                                 : cur_page_m1[PAGE_IDX_W-1:0];
    assign cnt_rd   = r_counts[cnt_addr];
    assign cur_cnt  = (cur_page == '0) ? '0 : cnt_rd;

    assign do_evict  = !r_hit && !r_empty_found;
    assign sel_frame = r_hit ? r_match_idx : (r_empty_found ? r_empty_idx : r_min_idx);

    assign o_stat.page_valid = r_page_valid;
    assign o_stat.scan_last  = (r_idx == last_idx);
    assign o_stat.out_free   = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_FRAMES; i++) begin
                r_frames[i] <= '0;
            end
            for (int i = 0; i < NUM_PAGES; i++) begin
                r_counts[i] <= '0;
            end
            r_frames_in_use <= CFG_W'(FRAMES_RESET);
            o_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_frames_in_use <= i_cfg_wdata;
            end
            if (i_cmd.commit) begin
                r_frames[sel_frame] <= r_page;
                if (do_evict) begin
                    r_counts[min_page_m1[PAGE_IDX_W-1:0]] <= '0;
                end
            end
            if (i_cmd.bump && (cnt_rd != COUNT_MAX)) begin
                r_counts[cnt_addr] <= cnt_rd + COUNT_WIDTH'(1);
            end
            if (i_cmd.out_load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_page        <= i_page_id;
            r_page_valid  <= page_ok;
            r_idx         <= '0;
            r_hit         <= 1'b0;
            r_empty_found <= 1'b0;
        end
        if (i_cmd.scan) begin
            r_idx <= r_idx + FRAME_W'(1);
            // keep the lowest frame that holds the page
            if (!r_hit && (cur_page == r_page)) begin
                r_hit       <= 1'b1;
                r_match_idx <= r_idx;
            end
            if (!r_empty_found && (cur_page == '0)) begin
                r_empty_found <= 1'b1;
                r_empty_idx   <= r_idx;
            end
            // strict less keeps the lowest frame on a tie
            if ((r_idx == '0) || (cur_cnt < r_min_cnt)) begin
                r_min_cnt  <= cur_cnt;
                r_min_idx  <= r_idx;
                r_min_page <= cur_page;
            end
        end
        if (i_cmd.commit) begin
            r_frame <= sel_frame;
            r_evict <= do_evict ? r_min_page : '0;
        end
        if (i_cmd.out_load) begin
            o_was_hit      <= r_page_valid && r_hit;
            o_frame_index  <= r_page_valid ? r_frame : '0;
            o_evicted_page <= r_page_valid ? r_evict : '0;
        end
    end

`ifndef ASSERT_OFF
    a_commit_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> (r_frames[r_frame] == r_page))
        else $error("committed frame does not hold the requested page");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_was_hit) |-> (o_evicted_page == '0))
        else $error("hit reported an evicted page");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan |-> (FRAME_CNT_W'(r_idx) < n_act))
        else $error("scan ran past the active frames");

    a_result_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (FRAME_CNT_W'(o_frame_index) < n_act))
        else $error("result frame outside the active frames");
`endif

endmodule
